@@ hdl/bis_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bis_pkg: shared types and constants of the bilinear image scaler
// Field widths, opcodes, register indexes, reset values and the
// controller-to-datapath command bundle.
// ============================================================================
package bis_pkg;

    // Request and result field widths
    localparam int OPC_W  = 1;
    localparam int COL_W  = 8;
    localparam int ROW_W  = 8;
    localparam int PIX_W  = 32;
    localparam int DCOL_W = 12;
    localparam int DROW_W = 12;
    localparam int CH_W   = 8;

    // Configuration register widths
    localparam int SW_W   = 9;
    localparam int SH_W   = 9;
    localparam int DW_W   = 13;
    localparam int STEP_W = 25;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 25;

    // 21.16 positions, 8-bit blend fractions
    localparam int FIX_SHIFT = 16;
    localparam int FRAC_W    = 8;

    // Default frame store geometry
    localparam int SRC_MAX_W_DEF = 256;
    localparam int SRC_MAX_H_DEF = 256;

    // Opcodes
    localparam logic [OPC_W-1:0] OP_LOAD   = 1'b0;
    localparam logic [OPC_W-1:0] OP_SAMPLE = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_X     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_Y     = 3'd4;

    // Register reset values
    localparam logic [SW_W-1:0]   SW_RST   = 9'd1;
    localparam logic [SH_W-1:0]   SH_RST   = 9'd1;
    localparam logic [DW_W-1:0]   DW_RST   = 13'd1;
    localparam logic [STEP_W-1:0] STEP_RST = 25'd65536;

    // Neighbour select for frame store reads
    typedef logic [1:0] t_rd_sel;
    localparam t_rd_sel RD_TL = 2'd0;
    localparam t_rd_sel RD_TR = 2'd1;
    localparam t_rd_sel RD_BL = 2'd2;
    localparam t_rd_sel RD_BR = 2'd3;

    // Controller commands to the datapath
    typedef struct packed {
        logic    load_we;
        logic    start;
        logic    cap_coord;
        t_rd_sel rd_sel;
        logic    cap_a;
        logic    cap_top;
        logic    cap_c;
        logic    cap_bot;
        logic    out_load;
    } t_dp_cmd;

endpackage

@@ hdl/bis_in_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bis_in_if: request channel of the scaler
// Valid/ready channel carrying a load or sample request.
// ============================================================================
interface bis_in_if;
    logic                         valid;
    logic                         ready;
    logic [bis_pkg::OPC_W-1:0]    opcode;
    logic [bis_pkg::COL_W-1:0]    src_col;
    logic [bis_pkg::ROW_W-1:0]    src_row;
    logic [bis_pkg::PIX_W-1:0]    pixel_in;
    logic [bis_pkg::DCOL_W-1:0]   dst_col;
    logic [bis_pkg::DROW_W-1:0]   dst_row;

    modport source (
        output valid, opcode, src_col, src_row, pixel_in, dst_col, dst_row,
        input  ready
    );
    modport sink (
        input  valid, opcode, src_col, src_row, pixel_in, dst_col, dst_row,
        output ready
    );
endinterface

@@ hdl/bis_out_if.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bis_out_if: result channel of the scaler
// Valid/ready channel carrying one interpolated pixel.
// ============================================================================
interface bis_out_if;
    logic                      valid;
    logic                      ready;
    logic [bis_pkg::PIX_W-1:0] pixel_out;

    modport source (output valid, pixel_out, input ready);
    modport sink   (input valid, pixel_out, output ready);
endinterface

@@ hdl/bilinear_image_scaler.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bilinear_image_scaler: ARGB8888 bilinear scaler top level
// Loads source pixels into an on-chip frame store and returns bilinearly
// interpolated destination pixels on request.
// ============================================================================
//
// Channel   Dir  Modport  Payload
// --------  ---  -------  ------------------------------------------------
// i_req     in   sink     opcode, src_col, src_row, pixel_in, dst_col, dst_row
// o_res     out  source   pixel_out
// i_cfg_*   in   -        write enable, register index, write data
//
// A load request leaves the block idle; i_req.ready stays high across loads.
// A sample request holds the block through the product, coordinates, four
// reads of the single-port frame store, then two blend steps.
// Reset is synchronous, active low; the frame store is not cleared.
// A finished pixel waits in the result register while the next request is
// taken; a second pixel holds in the final blend step until it drains.
//
module bilinear_image_scaler #(
    parameter int SRC_MAX_W = bis_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H = bis_pkg::SRC_MAX_H_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    bis_in_if.sink                         i_req,
    bis_out_if.source                      o_res
);

    // Commands from the sequencer to the datapath
    bis_pkg::t_dp_cmd cmd;

    // Sequencer: request acceptance, sample phases, result valid
    bis_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_in_opcode (i_req.opcode),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd)
    );

    // Datapath: registers, positions, frame store, blend
    bis_dp #(
        .SRC_MAX_W (SRC_MAX_W),
        .SRC_MAX_H (SRC_MAX_H)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_src_col   (i_req.src_col),
        .i_src_row   (i_req.src_row),
        .i_pixel_in  (i_req.pixel_in),
        .i_dst_col   (i_req.dst_col),
        .i_dst_row   (i_req.dst_row),
        .i_cmd       (cmd),
        .o_pixel_out (o_res.pixel_out)
    );

endmodule

@@ hdl/bis_ram.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bis_ram: single-port RAM
// One write or one read per cycle, registered read data.
// ============================================================================
module bis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hdl/bis_ctrl.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bis_ctrl: scaler sequencer
// Accepts requests, steps a sample through coordinate, read and blend
// phases, and owns the result valid flag.
// ============================================================================
module bis_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic [bis_pkg::OPC_W-1:0] i_in_opcode,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output bis_pkg::t_dp_cmd          o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_COORD = 3'd1;
    localparam logic [2:0] S_RD0   = 3'd2;
    localparam logic [2:0] S_RD1   = 3'd3;
    localparam logic [2:0] S_RD2   = 3'd4;
    localparam logic [2:0] S_RD3   = 3'd5;
    localparam logic [2:0] S_MIXB  = 3'd6;
    localparam logic [2:0] S_MIXV  = 3'd7;

    logic [2:0] r_state, n_state;
    logic       r_out_valid, n_out_valid;
    logic       accept;
    logic       slot_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign slot_free  = !r_out_valid || i_out_ready;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.rd_sel   = bis_pkg::RD_TL;
        o_cmd.load_we  = accept && (i_in_opcode == bis_pkg::OP_LOAD);
        o_cmd.start    = accept && (i_in_opcode == bis_pkg::OP_SAMPLE);
        case (r_state)
            S_IDLE: begin
                if (o_cmd.start) begin
                    n_state = S_COORD;
                end
            end
            S_COORD: begin
                o_cmd.cap_coord = 1'b1;
                n_state         = S_RD0;
            end
            S_RD0: begin
                o_cmd.rd_sel = bis_pkg::RD_TL;
                n_state      = S_RD1;
            end
            S_RD1: begin
                o_cmd.rd_sel = bis_pkg::RD_TR;
                o_cmd.cap_a  = 1'b1;
                n_state      = S_RD2;
            end
            S_RD2: begin
                o_cmd.rd_sel  = bis_pkg::RD_BL;
                o_cmd.cap_top = 1'b1;
                n_state       = S_RD3;
            end
            S_RD3: begin
                o_cmd.rd_sel = bis_pkg::RD_BR;
                o_cmd.cap_c  = 1'b1;
                n_state      = S_MIXB;
            end
            S_MIXB: begin
                o_cmd.cap_bot = 1'b1;
                n_state       = S_MIXV;
            end
            S_MIXV: begin
                // hold the blended pair until the result register frees up
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef NO_ASSERTIONS
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result loaded over a pending result");

    a_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_MIXV))
        else $error("result valid raised outside the final blend");

    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.start |=> (r_state == S_COORD))
        else $error("sample request did not enter coordinate phase");

    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD0) |-> ($past(r_state) == S_COORD))
        else $error("frame store reads began without coordinates");
`endif

endmodule

@@ hdl/bis_dp.sv @@
`timescale 1ns / 1ps
// ============================================================================
// bis_dp: scaler datapath
// Configuration registers, position multipliers, neighbour coordinates,
// frame store and the per-channel blend units.
// ============================================================================
module bis_dp #(
    parameter int SRC_MAX_W = bis_pkg::SRC_MAX_W_DEF,
    parameter int SRC_MAX_H = bis_pkg::SRC_MAX_H_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [bis_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [bis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [bis_pkg::COL_W-1:0]      i_src_col,
    input  logic [bis_pkg::ROW_W-1:0]      i_src_row,
    input  logic [bis_pkg::PIX_W-1:0]      i_pixel_in,
    input  logic [bis_pkg::DCOL_W-1:0]     i_dst_col,
    input  logic [bis_pkg::DROW_W-1:0]     i_dst_row,
    input  bis_pkg::t_dp_cmd               i_cmd,
    output logic [bis_pkg::PIX_W-1:0]      o_pixel_out
);

    localparam int CW    = $clog2(SRC_MAX_W);
    localparam int RW    = $clog2(SRC_MAX_H);
    localparam int DEPTH = SRC_MAX_W * SRC_MAX_H;
    localparam int AW    = $clog2(DEPTH);
    localparam int PX_W  = bis_pkg::DCOL_W + bis_pkg::STEP_W;
    localparam int PY_W  = bis_pkg::DROW_W + bis_pkg::STEP_W;
    localparam int XI_W  = PX_W - bis_pkg::FIX_SHIFT;
    localparam int YI_W  = PY_W - bis_pkg::FIX_SHIFT;
    localparam int FW    = bis_pkg::FRAC_W;
    localparam int CHW   = bis_pkg::CH_W;
    localparam int NCH   = bis_pkg::PIX_W / bis_pkg::CH_W;
    localparam int DWW   = bis_pkg::DW_W;

    // ---------------- configuration ----------------
    logic [bis_pkg::SW_W-1:0]   r_src_width;
    logic [bis_pkg::SH_W-1:0]   r_src_height;
    logic [bis_pkg::DW_W-1:0]   r_dst_width;
    logic [bis_pkg::STEP_W-1:0] r_step_x;
    logic [bis_pkg::STEP_W-1:0] r_step_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= bis_pkg::SW_RST;
            r_src_height <= bis_pkg::SH_RST;
            r_dst_width  <= bis_pkg::DW_RST;
            r_step_x     <= bis_pkg::STEP_RST;
            r_step_y     <= bis_pkg::STEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bis_pkg::CFG_SRC_WIDTH:  r_src_width  <= i_cfg_data[bis_pkg::SW_W-1:0];
                bis_pkg::CFG_SRC_HEIGHT: r_src_height <= i_cfg_data[bis_pkg::SH_W-1:0];
                bis_pkg::CFG_DST_WIDTH:  r_dst_width  <= i_cfg_data[bis_pkg::DW_W-1:0];
                bis_pkg::CFG_STEP_X:     r_step_x     <= i_cfg_data[bis_pkg::STEP_W-1:0];
                bis_pkg::CFG_STEP_Y:     r_step_y     <= i_cfg_data[bis_pkg::STEP_W-1:0];
                default: ;
            endcase
        end
    end

    // Last valid source column and row; zero counts as one, oversize saturates
    logic [CW-1:0] wm1;
    logic [RW-1:0] hm1;

    always_comb begin
        if (r_src_width == '0) begin
            wm1 = '0;
        end else if (32'(r_src_width) > SRC_MAX_W) begin
            wm1 = CW'(SRC_MAX_W - 1);
        end else begin
            wm1 = CW'(r_src_width - 1'b1);
        end
        if (r_src_height == '0) begin
            hm1 = '0;
        end else if (32'(r_src_height) > SRC_MAX_H) begin
            hm1 = RW'(SRC_MAX_H - 1);
        end else begin
            hm1 = RW'(r_src_height - 1'b1);
        end
    end

    // ---------------- position products ----------------
    logic [PX_W-1:0]              r_ix;
    logic [PY_W-1:0]              r_iy;
    logic [bis_pkg::DCOL_W-1:0]   r_dst_col;

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_ix      <= PX_W'(i_dst_col) * PX_W'(r_step_x);
            r_iy      <= PY_W'(i_dst_row) * PY_W'(r_step_y);
            r_dst_col <= i_dst_col;
        end
    end

    // ---------------- neighbour coordinates ----------------
    logic [XI_W-1:0] ix_int;
    logic [YI_W-1:0] iy_int;
    logic [CW-1:0]   x_sat, x_nxt;
    logic [RW-1:0]   y_sat, y_nxt;
    logic            last_col;

    logic [CW-1:0]   r_x, r_x1;
    logic [RW-1:0]   r_y, r_y1;
    logic [FW-1:0]   r_fx, r_fy;

    assign ix_int   = r_ix[PX_W-1:bis_pkg::FIX_SHIFT];
    assign iy_int   = r_iy[PY_W-1:bis_pkg::FIX_SHIFT];
    assign x_sat    = (ix_int > XI_W'(wm1)) ? wm1 : ix_int[CW-1:0];
    assign x_nxt    = (ix_int >= XI_W'(wm1)) ? wm1 : ix_int[CW-1:0] + 1'b1;
    assign y_sat    = (iy_int > YI_W'(hm1)) ? hm1 : iy_int[RW-1:0];
    assign y_nxt    = (iy_int >= YI_W'(hm1)) ? hm1 : iy_int[RW-1:0] + 1'b1;
    assign last_col = (r_dst_width != '0) && ((DWW'(r_dst_col) + 1'b1) == r_dst_width);

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_coord) begin
            // last column: both horizontal neighbours are column w-1
            r_x  <= last_col ? wm1 : x_sat;
            r_x1 <= last_col ? wm1 : x_nxt;
            r_y  <= y_sat;
            r_y1 <= y_nxt;
            r_fx <= r_ix[bis_pkg::FIX_SHIFT-1 -: FW];
            r_fy <= r_iy[bis_pkg::FIX_SHIFT-1 -: FW];
        end
    end

    // ---------------- frame store ----------------
    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] c, input logic [RW-1:0] r);
        return AW'(r) * AW'(SRC_MAX_W) + AW'(c);
    endfunction

    logic          load_in_range;
    logic [CW-1:0] rd_col;
    logic [RW-1:0] rd_row;
    logic [AW-1:0] ram_addr;
    logic          ram_we;
    logic [bis_pkg::PIX_W-1:0] ram_rdata;

    assign load_in_range = (32'(i_src_col) < SRC_MAX_W) && (32'(i_src_row) < SRC_MAX_H);
    assign ram_we        = i_cmd.load_we && load_in_range;

    always_comb begin
        case (i_cmd.rd_sel)
            bis_pkg::RD_TL: begin rd_col = r_x;  rd_row = r_y;  end
            bis_pkg::RD_TR: begin rd_col = r_x1; rd_row = r_y;  end
            bis_pkg::RD_BL: begin rd_col = r_x;  rd_row = r_y1; end
            bis_pkg::RD_BR: begin rd_col = r_x1; rd_row = r_y1; end
            default:        begin rd_col = r_x;  rd_row = r_y;  end
        endcase
    end

    assign ram_addr = i_cmd.load_we ? addr_of(CW'(i_src_col), RW'(i_src_row))
                                    : addr_of(rd_col, rd_row);

    bis_ram #(
        .WIDTH (bis_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (i_pixel_in),
        .o_rdata (ram_rdata)
    );

    // ---------------- blend ----------------
    function automatic logic [CHW-1:0] mix_chan(input logic [CHW-1:0] a,
                                                input logic [CHW-1:0] b,
                                                input logic [FW-1:0]  f);
        logic [CHW+FW-1:0] prod;
        logic [CHW+FW:0]   rnd;
        if (b >= a) begin
            prod = (CHW+FW)'(b - a) * (CHW+FW)'(f);
            return a + prod[CHW+FW-1:FW];
        end else begin
            // round toward minus infinity on a falling edge
            prod = (CHW+FW)'(a - b) * (CHW+FW)'(f);
            rnd  = (CHW+FW+1)'(prod) + (CHW+FW+1)'({FW{1'b1}});
            return a - rnd[CHW+FW-1:FW];
        end
    endfunction

    function automatic logic [bis_pkg::PIX_W-1:0] mix_pixel(
        input logic [bis_pkg::PIX_W-1:0] c1,
        input logic [bis_pkg::PIX_W-1:0] c2,
        input logic [FW-1:0]             f
    );
        logic [bis_pkg::PIX_W-1:0] res;
        res = '0;
        for (int k = 0; k < NCH; k++) begin
            res[k*CHW +: CHW] = mix_chan(c1[k*CHW +: CHW], c2[k*CHW +: CHW], f);
        end
        return res;
    endfunction

    logic [bis_pkg::PIX_W-1:0] r_pa, r_pc, r_top, r_bot, r_pixel_out;

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_a) begin
            r_pa <= ram_rdata;
        end
        if (i_cmd.cap_top) begin
            r_top <= mix_pixel(r_pa, ram_rdata, r_fx);
        end
        if (i_cmd.cap_c) begin
            r_pc <= ram_rdata;
        end
        if (i_cmd.cap_bot) begin
            r_bot <= mix_pixel(r_pc, ram_rdata, r_fx);
        end
        if (i_cmd.out_load) begin
            r_pixel_out <= mix_pixel(r_top, r_bot, r_fy);
        end
    end

    assign o_pixel_out = r_pixel_out;

endmodule

@@ dv/tb_bilinear_image_scaler.sv @@
`timescale 1ns / 1ps
// ============================================================================
// tb_bilinear_image_scaler: self-checking testbench of the bilinear scaler
// Loads ARGB pixels into the frame store and samples destination pixels
// under a series of register settings and flow-control patterns. Each
// sample request is predicted from a private copy of the frame store and
// registers; each returned pixel is checked against the oldest prediction.
// ============================================================================
module tb_bilinear_image_scaler;
    import bis_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RST_CYCLES   = 11;
    localparam int DRAIN_CYCLES = 16;
    localparam int STORE_W      = SRC_MAX_W_DEF;
    localparam int STORE_H      = SRC_MAX_H_DEF;
    localparam int DCOL_MAX     = (1 << DCOL_W) - 1;
    localparam int DROW_MAX     = (1 << DROW_W) - 1;
    localparam int ONE_FIX      = 1 << FIX_SHIFT;

    typedef struct {
        logic [OPC_W-1:0]  opcode;
        logic [COL_W-1:0]  src_col;
        logic [ROW_W-1:0]  src_row;
        logic [PIX_W-1:0]  pixel_in;
        logic [DCOL_W-1:0] dst_col;
        logic [DROW_W-1:0] dst_row;
    } scale_req_t;

    // Flow-control patterns applied per phase
    typedef enum int {
        FLOW_FREE,
        FLOW_SRC_GAPS,
        FLOW_SNK_STALLS,
        FLOW_BOTH
    } flow_t;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bis_in_if  req_if ();
    bis_out_if res_if ();

    bilinear_image_scaler DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_req       (req_if),
        .o_res       (res_if)
    );

    // Register copies, starting from the reset values
    logic [SW_W-1:0]   src_w_reg  = SW_RST;
    logic [SH_W-1:0]   src_h_reg  = SH_RST;
    logic [DW_W-1:0]   dst_w_reg  = DW_RST;
    logic [STEP_W-1:0] step_x_reg = STEP_RST;
    logic [STEP_W-1:0] step_y_reg = STEP_RST;

    // Frame store copy (updated on accepted loads) and the generator's record
    // of which entries have been loaded so far
    logic [PIX_W-1:0] frame_copy   [STORE_W*STORE_H];
    bit               frame_loaded [STORE_W*STORE_H];

    scale_req_t       req_pending[$];
    logic [PIX_W-1:0] expected_pixels[$];
    int               n_queued;
    int               n_accepted;
    int               n_errors;
    flow_t            flow;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Width or height of zero counts as one; above the store size saturates.
    function automatic int clamp_dim(input int v, input int maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic int store_addr(input int col, input int row);
        return row * STORE_W + col;
    endfunction

    // Work out the source neighbours and the blend fractions of a sample.
    function automatic void locate(input logic [DCOL_W-1:0] dc, input logic [DROW_W-1:0] dr,
                                   output int x, output int y, output int x1, output int y1,
                                   output int fx, output int fy, output bit last_col);
        logic [63:0] ix;
        logic [63:0] iy;
        int          w;
        int          h;
        w  = clamp_dim(int'(src_w_reg), STORE_W);
        h  = clamp_dim(int'(src_h_reg), STORE_H);
        ix = 64'(dc) * 64'(step_x_reg);
        iy = 64'(dr) * 64'(step_y_reg);
        fx = int'(ix[FIX_SHIFT-1 -: FRAC_W]);
        fy = int'(iy[FIX_SHIFT-1 -: FRAC_W]);
        ix = ix >> FIX_SHIFT;
        iy = iy >> FIX_SHIFT;
        // Positions past the image saturate; the fractions stay as computed
        x  = (ix > 64'(w - 1)) ? w - 1 : int'(ix);
        y  = (iy > 64'(h - 1)) ? h - 1 : int'(iy);
        x1 = (x + 1 > w - 1) ? w - 1 : x + 1;
        y1 = (y + 1 > h - 1) ? h - 1 : y + 1;
        last_col = (dst_w_reg != '0) && (int'(dc) + 1 == int'(dst_w_reg));
    endfunction

    // a + floor((b - a) * f / 256), with the floor taken toward minus infinity
    function automatic int blend_ch(input int a, input int b, input int f);
        if (b >= a) return a + (((b - a) * f) >> FRAC_W);
        return a - ((((a - b) * f) + 255) >> FRAC_W);
    endfunction

    function automatic logic [PIX_W-1:0] blend_px(input logic [PIX_W-1:0] c1,
                                                  input logic [PIX_W-1:0] c2, input int f);
        logic [PIX_W-1:0] res;
        res = '0;
        for (int s = 0; s < PIX_W; s += CH_W) begin
            res[s +: CH_W] = CH_W'(blend_ch(int'(c1[s +: CH_W]), int'(c2[s +: CH_W]), f));
        end
        return res;
    endfunction

    function automatic logic [PIX_W-1:0] interp_pixel(input logic [DCOL_W-1:0] dc,
                                                      input logic [DROW_W-1:0] dr);
        int               x;
        int               y;
        int               x1;
        int               y1;
        int               fx;
        int               fy;
        int               w;
        bit               last_col;
        logic [PIX_W-1:0] top;
        logic [PIX_W-1:0] bot;
        locate(dc, dr, x, y, x1, y1, fx, fy, last_col);
        w = clamp_dim(int'(src_w_reg), STORE_W);
        // Last destination column blends the last source column vertically only
        if (last_col) begin
            return blend_px(frame_copy[store_addr(w - 1, y)],
                            frame_copy[store_addr(w - 1, y1)], fy);
        end
        top = blend_px(frame_copy[store_addr(x, y)], frame_copy[store_addr(x1, y)], fx);
        bot = blend_px(frame_copy[store_addr(x, y1)], frame_copy[store_addr(x1, y1)], fx);
        return blend_px(top, bot, fy);
    endfunction

    // ------------------------------------------------------------------------
    // Request generation
    // ------------------------------------------------------------------------

    // Bias pixels toward full-range channel steps in both directions.
    function automatic logic [PIX_W-1:0] rand_pixel();
        case ($urandom_range(0, 11))
            0: return '0;
            1: return '1;
            2: return 32'hFF00FF00;
            3: return 32'h00FF00FF;
            default: return $urandom();
        endcase
    endfunction

    task automatic push_load(input int col, input int row, input logic [PIX_W-1:0] pix);
        scale_req_t r;
        r.opcode   = OP_LOAD;
        r.src_col  = COL_W'(col);
        r.src_row  = ROW_W'(row);
        r.pixel_in = pix;
        // Unused by a load: fill with noise
        r.dst_col  = DCOL_W'($urandom());
        r.dst_row  = DROW_W'($urandom());
        req_pending.push_back(r);
        frame_loaded[store_addr(col, row)] = 1'b1;
        n_queued++;
    endtask

    task automatic need_pixel(input int col, input int row);
        if (!frame_loaded[store_addr(col, row)]) push_load(col, row, rand_pixel());
    endtask

    // Queue a sample, preceded by loads of any neighbour not yet written.
    task automatic push_sample(input int dc, input int dr);
        scale_req_t r;
        int         x;
        int         y;
        int         x1;
        int         y1;
        int         fx;
        int         fy;
        int         w;
        bit         last_col;
        locate(DCOL_W'(dc), DROW_W'(dr), x, y, x1, y1, fx, fy, last_col);
        w = clamp_dim(int'(src_w_reg), STORE_W);
        need_pixel(x, y);
        need_pixel(x1, y);
        need_pixel(x, y1);
        need_pixel(x1, y1);
        need_pixel(w - 1, y);
        need_pixel(w - 1, y1);
        r.opcode   = OP_SAMPLE;
        r.src_col  = COL_W'($urandom());
        r.src_row  = ROW_W'($urandom());
        r.pixel_in = $urandom();
        r.dst_col  = DCOL_W'(dc);
        r.dst_row  = DROW_W'(dr);
        req_pending.push_back(r);
        n_queued++;
    endtask

    // ------------------------------------------------------------------------
    // Configuration and phase control
    // ------------------------------------------------------------------------

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(val);
        case (idx)
            CFG_SRC_WIDTH:  src_w_reg  = SW_W'(val);
            CFG_SRC_HEIGHT: src_h_reg  = SH_W'(val);
            CFG_DST_WIDTH:  dst_w_reg  = DW_W'(val);
            CFG_STEP_X:     step_x_reg = STEP_W'(val);
            CFG_STEP_Y:     step_y_reg = STEP_W'(val);
            default: ;
        endcase
    endtask

    // Hold until every request is taken and every pixel is back, then let
    // a trailing load or stray result settle.
    task automatic wait_drained();
        while (req_pending.size() != 0 || n_accepted != n_queued
               || expected_pixels.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Directed requests for a 2x2 source scaled to 3 columns.
    task automatic add_directed();
        push_load(0, 0, 32'h00000000);
        push_load(1, 0, 32'hFFFFFFFF);
        push_load(0, 1, 32'hFF00FF00);
        push_load(1, 1, 32'h00FF00FF);
        push_load(255, 255, 32'h12345678);  // outside the image, inside the store
        push_sample(0, 0);                  // exact pixel
        push_sample(1, 0);                  // rising horizontal blend
        push_sample(1, 1);                  // mixed rising and falling channels
        push_sample(2, 1);                  // last destination column
        push_sample(3, 3);                  // column beyond dst_width
        push_sample(DCOL_MAX, DROW_MAX);    // position past the image
        push_sample(DCOL_MAX, 0);
        push_sample(0, DROW_MAX);
        push_load(0, 0, 32'hFFFFFFFF);
        push_load(1, 0, 32'h00000000);
        push_sample(1, 0);                  // falling horizontal blend
    endtask

    // Program one register setting (sw < 0 keeps the reset values; a negative
    // step is derived from the sizes), then queue the phase's requests.
    task automatic run_phase(input int sw, input int sh, input int dw, input int dh,
                             input int sx, input int sy, input flow_t fm,
                             input int budget, input bit directed);
        int base;
        int w;
        int h;
        int span;
        int dc;
        int dr;
        wait_drained();
        if (sw >= 0) begin
            write_reg(CFG_SRC_WIDTH, sw);
            write_reg(CFG_SRC_HEIGHT, sh);
            write_reg(CFG_DST_WIDTH, dw);
            write_reg(CFG_STEP_X, (sx < 0) ? (sw * ONE_FIX) / dw : sx);
            write_reg(CFG_STEP_Y, (sy < 0) ? (sh * ONE_FIX) / dh : sy);
            @(posedge i_clk);
            cfg_we <= 1'b0;
        end
        flow <= fm;
        // Fill the queue away from the clock edge
        @(negedge i_clk);
        if (directed) add_directed();
        w    = clamp_dim(int'(src_w_reg), STORE_W);
        h    = clamp_dim(int'(src_h_reg), STORE_H);
        span = clamp_dim(int'(dst_w_reg), DCOL_MAX + 1);
        base = n_queued;
        while (n_queued - base < budget) begin
            if ($urandom_range(0, 99) < 40) begin
                if ($urandom_range(0, 3) == 0) begin
                    push_load($urandom_range(0, STORE_W - 1), $urandom_range(0, STORE_H - 1),
                              rand_pixel());
                end else begin
                    push_load($urandom_range(0, w - 1), $urandom_range(0, h - 1), rand_pixel());
                end
            end else begin
                case ($urandom_range(0, 7))
                    0: dc = $urandom_range(0, DCOL_MAX);
                    1: dc = span - 1;
                    default: dc = $urandom_range(0, span);
                endcase
                if (dc > DCOL_MAX) dc = DCOL_MAX;
                dr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, DROW_MAX)
                                                 : $urandom_range(0, dh - 1);
                push_sample(dc, dr);
            end
        end
    endtask

    function automatic int gap_pct(input flow_t fm, input bit sender);
        case (fm)
            FLOW_SRC_GAPS:   return sender ? 61 : 0;
            FLOW_SNK_STALLS: return sender ? 0 : 61;
            FLOW_BOTH:       return 7;
            default:         return 0;
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Clock, driver, receiver and monitor
    // ------------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Request driver: hold a request until it is taken, then advance to the
    // next pending one unless this cycle is an idle gap.
    always @(posedge i_clk) begin
        scale_req_t r;
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else if (!req_if.valid || req_if.ready) begin
            if (req_pending.size() != 0 && $urandom_range(0, 99) >= gap_pct(flow, 1'b1)) begin
                r = req_pending.pop_front();
                req_if.valid    <= 1'b1;
                req_if.opcode   <= r.opcode;
                req_if.src_col  <= r.src_col;
                req_if.src_row  <= r.src_row;
                req_if.pixel_in <= r.pixel_in;
                req_if.dst_col  <= r.dst_col;
                req_if.dst_row  <= r.dst_row;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stall at random according to the phase pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= gap_pct(flow, 1'b0));
        end
    end

    // Monitor: check returned pixels first, then predict from accepted
    // requests (a request never returns its pixel in the cycle it is taken).
    always @(posedge i_clk) begin
        logic [PIX_W-1:0] want;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                if (expected_pixels.size() == 0) begin
                    $display("%0t: unexpected pixel_out: expected none actual %08h",
                             $time, res_if.pixel_out);
                    n_errors++;
                end else begin
                    want = expected_pixels.pop_front();
                    if (res_if.pixel_out !== want) begin
                        $display("%0t: pixel_out mismatch: expected %08h actual %08h",
                                 $time, want, res_if.pixel_out);
                        n_errors++;
                    end
                end
            end
            if (req_if.valid && req_if.ready) begin
                n_accepted++;
                if (req_if.opcode == OP_LOAD) begin
                    frame_copy[store_addr(int'(req_if.src_col), int'(req_if.src_row))] =
                        req_if.pixel_in;
                end else begin
                    expected_pixels.push_back(interp_pixel(req_if.dst_col, req_if.dst_row));
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------

    initial begin
        i_rst_n         = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        flow            = FLOW_FREE;
        n_queued        = 0;
        n_accepted      = 0;
        n_errors        = 0;
        req_if.valid    = 1'b0;
        req_if.opcode   = OP_LOAD;
        req_if.src_col  = '0;
        req_if.src_row  = '0;
        req_if.pixel_in = '0;
        req_if.dst_col  = '0;
        req_if.dst_row  = '0;
        res_if.ready    = 1'b0;
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset register values: 1x1 source, every sample is the same pixel
        run_phase(-1, 0, 0, 1, 0, 0, FLOW_FREE, 60, 1'b0);
        run_phase(2, 2, 3, 3, -1, -1, FLOW_FREE, 150, 1'b1);
        run_phase(8, 6, 13, 11, -1, -1, FLOW_SRC_GAPS, 200, 1'b0);
        run_phase(256, 256, 4096, 4096, -1, -1, FLOW_SNK_STALLS, 200, 1'b0);
        // Out-of-range sizes, no last-column rule, zero steps and a step of 2^24
        run_phase(0, 511, 0, 64, 0, 16777216, FLOW_BOTH, 150, 1'b0);
        run_phase(256, 1, 1, 16, 16777216, 0, FLOW_FREE, 150, 1'b0);
        run_phase(17, 33, 40, 70, -1, (1 << STEP_W) - 1, FLOW_SRC_GAPS, 200, 1'b0);
        run_phase(5, 3, 2, 9, -1, -1, FLOW_SNK_STALLS, 200, 1'b0);
        run_phase(256, 200, 100, 4000, -1, -1, FLOW_BOTH, 200, 1'b0);
        for (int i = 0; i < 3; i++) begin
            run_phase($urandom_range(1, 256), $urandom_range(1, 256),
                      $urandom_range(1, DCOL_MAX + 1), $urandom_range(1, DROW_MAX + 1),
                      -1, -1, flow_t'(i), 150, 1'b0);
        end

        wait_drained();
        if (n_errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial begin
        #(CLK_HALF * 2 * 1000000);
        $display("Regression FAIL");
        $finish;
    end

endmodule
